FILE: sv/apst_pkg.sv
// package for the average pool, scale and tanh block: sizes, item types, register codes, tanh table
`timescale 1ns / 1ps
`default_nettype none

package apst_pkg;

  // plane geometry
  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SLOT_W     = $clog2(LINE_DEPTH);
  localparam int SIZE_W     = 6;
  localparam int DIM_W      = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;

  // datapath widths
  localparam int PIX_W  = 16;
  localparam int PAIR_W = PIX_W + 1;
  localparam int SUM_W  = PIX_W + 2;
  localparam int COEF_W = 16;
  localparam int PROD_W = SUM_W + COEF_W;
  localparam int SHIFT  = 14;
  localparam int SCL_W  = PROD_W + 1 - SHIFT;
  localparam int PRE_W  = SCL_W + 1;
  localparam int OUT_W  = 14;

  // tanh table
  localparam int TANH_DEPTH = 256;
  localparam int TIDX_W     = $clog2(TANH_DEPTH);
  localparam int TANH_W     = 13;

  // output queue
  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_WIDTH  = 2'd0,
    REG_PLANE_HEIGHT = 2'd1,
    REG_POOL_COEF    = 2'd2,
    REG_OFFSET_TERM  = 2'd3
  } reg_index_t;

  // pair-sum request travelling down the line cells
  typedef struct packed {
    logic                     valid;
    logic                     wr;
    logic                     rd;
    logic                     live;
    logic                     done;
    logic [SLOT_W-1:0]        hop;
    logic signed [PAIR_W-1:0] pair;
    logic signed [PAIR_W-1:0] line;
  } token_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] pooled;
    logic                    done;
  } result_t;

  typedef logic [TANH_DEPTH-1:0][TANH_W-1:0] tanh_table_t;

  // shift and subtract quotient, only evaluated while the table is built
  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // entry k = tanh((k + 1/2) * 8 / depth) in Q.12, built in Q1.31 from exp(-2x)
  function automatic tanh_table_t build_tanh_table();
    tanh_table_t         tbl;
    longint unsigned     q31_one;
    longint unsigned     y;
    longint unsigned     z;
    longint unsigned     term;
    longint unsigned     v;
    longint unsigned     num;
    longint unsigned     den;
    longint              sum;
    q31_one = 64'd2147483648;
    for (int k = 0; k < TANH_DEPTH; k++) begin
      y    = (longint'(2 * k + 1) << 34) >> TIDX_W;
      z    = y >> 4;
      term = q31_one;
      sum  = longint'(q31_one);
      for (int i = 1; i <= 16; i++) begin
        term = div_u64((term * z) >> 31, longint'(i));
        if (i[0]) sum = sum - longint'(term);
        else      sum = sum + longint'(term);
        if (sum < 0) sum = 0;
        if (sum > longint'(q31_one)) sum = longint'(q31_one);
      end
      v = longint'(sum);
      for (int i = 0; i < 4; i++) begin
        v = (v * v) >> 31;
      end
      num    = (q31_one - v) << 12;
      den    = q31_one + v;
      tbl[k] = TANH_W'(div_u64(num + (den >> 1), den));
    end
    return tbl;
  endfunction

  localparam tanh_table_t TANH_TABLE = build_tanh_table();

endpackage

`default_nettype wire

FILE: sv/apst_in_if.sv
// pixel input channel
`timescale 1ns / 1ps
`default_nettype none

interface apst_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [apst_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

`default_nettype wire

FILE: sv/apst_out_if.sv
// pooled result output channel
`timescale 1ns / 1ps
`default_nettype none

interface apst_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [apst_pkg::OUT_W-1:0] pooled_value;
  logic                              plane_done;

  modport source (output valid, output pooled_value, output plane_done, input ready);
  modport sink   (input valid, input pooled_value, input plane_done, output ready);
endinterface

`default_nettype wire

FILE: sv/apst_cfg_if.sv
// register write channel
`timescale 1ns / 1ps
`default_nettype none

interface apst_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [apst_pkg::CFG_IDX_W-1:0]     index;
  logic [apst_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/avg_pool_scale_tanh.sv
// top level: 2x2 average pool with channel scale and bias, then tanh
//
//   channel   direction  payload                         accepted when
//   pixels    in         pixel_value (s16 Q4.12)         valid && ready
//   results   out        pooled_value (s14), plane_done  valid && ready
//   regs      in         index (2b), data (16b)          valid && ready (ready always high)
//
// one pixel per cycle unless stalled; a pixel reaches its result through one input stage,
// the line cells one after another (16 cells) and four arithmetic stages, then the queue.
// the line store is spread over the cells, so a pair-sum request walks the chain to its cell.
// reset clears counters, left pixel, request valids and the queue; line cell entries hold no reset.
// pixels stall only when the 16-entry result queue would be overcommitted by a blocked output.
`timescale 1ns / 1ps
`default_nettype none

module avg_pool_scale_tanh (
  input  logic        clk,
  input  logic        rst,
  apst_in_if.sink     pixels,
  apst_out_if.source  results,
  apst_cfg_if.sink    regs
);
  import apst_pkg::*;

  logic [SIZE_W-1:0]        plane_width;
  logic [SIZE_W-1:0]        plane_height;
  logic signed [COEF_W-1:0] pool_coefficient;
  logic signed [PIX_W-1:0]  offset_term;

  logic                     accept;
  logic                     yields;
  logic                     pop;
  logic [QCNT_W-1:0]        pending;
  logic [QCNT_W-1:0]        pending_next;
  token_t                   chain [LINE_DEPTH + 1];
  logic                     res_valid;
  result_t                  res;
  logic                     head_valid;
  result_t                  head;

  // register writes
  assign regs.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_width      <= SIZE_W'(28);
      plane_height     <= SIZE_W'(28);
      pool_coefficient <= COEF_W'(4096);
      offset_term      <= '0;
    end else if (regs.valid) begin
      unique case (reg_index_t'(regs.index))
        REG_PLANE_WIDTH:  plane_width      <= regs.data[SIZE_W-1:0];
        REG_PLANE_HEIGHT: plane_height     <= regs.data[SIZE_W-1:0];
        REG_POOL_COEF:    pool_coefficient <= signed'(regs.data);
        REG_OFFSET_TERM:  offset_term      <= signed'(regs.data);
        default: ;
      endcase
    end
  end

  // results owed, in flight or queued; keeps the queue from overflowing
  assign accept = pixels.valid && pixels.ready;
  assign pop    = results.valid && results.ready;

  always_comb begin
    pending_next = pending;
    if (yields && !pop) pending_next = pending + QCNT_W'(1);
    if (pop && !yields) pending_next = pending - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else     pending <= pending_next;
  end

  assign pixels.ready = pending < QCNT_W'(QUEUE_DEPTH);

  apst_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .pixel        (pixels.pixel_value),
    .plane_width  (plane_width),
    .plane_height (plane_height),
    .tok          (chain[0]),
    .yields       (yields)
  );

  for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
    apst_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  apst_math u_math (
    .clk       (clk),
    .rst       (rst),
    .tok       (chain[LINE_DEPTH]),
    .coef      (pool_coefficient),
    .bias      (offset_term),
    .res_valid (res_valid),
    .res       (res)
  );

  apst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  assign results.valid        = head_valid;
  assign results.pooled_value = head.pooled;
  assign results.plane_done   = head.done;

endmodule

`default_nettype wire

FILE: sv/apst_front.sv
// raster counters, left pixel and pair-sum request builder
`timescale 1ns / 1ps
`default_nettype none

module apst_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic signed [apst_pkg::PIX_W-1:0] pixel,
  input  logic [apst_pkg::SIZE_W-1:0]      plane_width,
  input  logic [apst_pkg::SIZE_W-1:0]      plane_height,
  output apst_pkg::token_t                 tok,
  output logic                             yields
);
  import apst_pkg::*;

  localparam logic [DIM_W-1:0] W_LIM = DIM_W'(MAX_WIDTH - MAX_WIDTH % 2);
  localparam logic [DIM_W-1:0] H_LIM = DIM_W'(MAX_HEIGHT - MAX_HEIGHT % 2);
  localparam logic [DIM_W-1:0] MIN_DIM = DIM_W'(2);

  logic [COL_W-1:0]         column_count;
  logic [COL_W-1:0]         column_count_next;
  logic [ROW_W-1:0]         row_count;
  logic [ROW_W-1:0]         row_count_next;
  logic signed [PIX_W-1:0]  left_pixel;
  logic [DIM_W-1:0]         w_eff;
  logic [DIM_W-1:0]         h_eff;
  logic [DIM_W-1:0]         col_ext;
  logic [DIM_W-1:0]         row_ext;
  logic [DIM_W-1:0]         col_plus;
  logic [DIM_W-1:0]         row_plus;
  logic                     col_wrap;
  token_t                   tok_next;

  // sizes: low bit cleared, limited to [2, max]
  always_comb begin
    w_eff = DIM_W'({plane_width[SIZE_W-1:1], 1'b0});
    if (w_eff < MIN_DIM) w_eff = MIN_DIM;
    if (w_eff > W_LIM)   w_eff = W_LIM;
    h_eff = DIM_W'({plane_height[SIZE_W-1:1], 1'b0});
    if (h_eff < MIN_DIM) h_eff = MIN_DIM;
    if (h_eff > H_LIM)   h_eff = H_LIM;
  end

  assign col_ext  = DIM_W'(column_count);
  assign row_ext  = DIM_W'(row_count);
  assign col_plus = col_ext + DIM_W'(1);
  assign row_plus = row_ext + DIM_W'(1);
  assign col_wrap = col_plus >= w_eff;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (accept) begin
      if (col_wrap) begin
        column_count_next = '0;
        row_count_next    = (row_plus >= h_eff) ? '0 : ROW_W'(row_plus);
      end else begin
        column_count_next = COL_W'(col_plus);
      end
    end
  end

  always_comb begin
    tok_next.valid = accept && column_count[0];
    tok_next.wr    = !row_count[0];
    tok_next.rd    = row_count[0];
    tok_next.live  = 1'b1;
    tok_next.done  = (row_ext == h_eff - DIM_W'(1)) && (col_ext == w_eff - DIM_W'(1));
    tok_next.hop   = column_count[COL_W-1:1];
    tok_next.pair  = PAIR_W'(left_pixel) + PAIR_W'(pixel);
    tok_next.line  = '0;
  end

  assign yields = accept && column_count[0] && row_count[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      left_pixel   <= '0;
      tok.valid    <= 1'b0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (accept && !column_count[0]) left_pixel <= pixel;
      tok          <= tok_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/apst_cell.sv
// one line cell: holds one column pair's sum and passes requests on
`timescale 1ns / 1ps
`default_nettype none

module apst_cell (
  input  logic             clk,
  input  logic             rst,
  input  apst_pkg::token_t tok_in,
  output apst_pkg::token_t tok_out
);
  import apst_pkg::*;

  logic signed [PAIR_W-1:0] entry;
  logic                     hit;
  token_t                   tok_next;

  // a request acts in the cell where its hop count runs out
  assign hit = tok_in.valid && tok_in.live && (tok_in.hop == '0);

  always_comb begin
    tok_next      = tok_in;
    tok_next.hop  = tok_in.hop - SLOT_W'(1);
    tok_next.live = tok_in.live && !hit;
    if (hit && tok_in.rd) tok_next.line = entry;
  end

  always_ff @(posedge clk) begin
    if (hit && tok_in.wr) entry <= tok_in.pair;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/apst_math.sv
// 2x2 sum, channel scale, bias, saturation and tanh lookup
`timescale 1ns / 1ps
`default_nettype none

module apst_math (
  input  logic                              clk,
  input  logic                              rst,
  input  apst_pkg::token_t                  tok,
  input  logic signed [apst_pkg::COEF_W-1:0] coef,
  input  logic signed [apst_pkg::PIX_W-1:0]  bias,
  output logic                              res_valid,
  output apst_pkg::result_t                 res
);
  import apst_pkg::*;

  localparam logic signed [PRE_W-1:0] SAT_HI = PRE_W'(32767);
  localparam logic signed [PRE_W-1:0] SAT_LO = PRE_W'(-32768);
  localparam int IDX_FULL_W = PIX_W + 1 + TIDX_W;

  // stage 1: 2x2 sum
  logic                    v1;
  logic                    done1;
  logic signed [SUM_W-1:0] sum4;
  // stage 2: product
  logic                     v2;
  logic                     done2;
  logic signed [PROD_W-1:0] prod;
  // stage 3: saturated pre-activation
  logic                     v3;
  logic                     done3;
  logic signed [PIX_W-1:0]  pre;

  logic signed [PROD_W:0]   rounded;
  logic signed [SCL_W-1:0]  scaled;
  logic signed [PRE_W-1:0]  pre_wide;
  logic signed [PIX_W-1:0]  pre_next;
  logic [PIX_W:0]           pre_ext;
  logic [PIX_W:0]           mag;
  logic [IDX_FULL_W-1:0]    idx_full;
  logic [TIDX_W-1:0]        idx;
  logic [OUT_W-1:0]         entry;
  result_t                  res_next;

  // quarter scale with round half up, back to Q.12
  always_comb begin
    rounded  = (PROD_W + 1)'(prod) + (PROD_W + 1)'(8192);
    scaled   = rounded[PROD_W:SHIFT];
    pre_wide = PRE_W'(scaled) + PRE_W'(bias);
    if (pre_wide > SAT_HI)      pre_next = PIX_W'(SAT_HI);
    else if (pre_wide < SAT_LO) pre_next = PIX_W'(SAT_LO);
    else                        pre_next = PIX_W'(pre_wide);
  end

  always_comb begin
    pre_ext  = {pre[PIX_W-1], pre};
    mag      = pre_ext[PIX_W] ? (~pre_ext + (PIX_W + 1)'(1)) : pre_ext;
    idx_full = (IDX_FULL_W'(mag) << TIDX_W) >> 15;
    if (idx_full >= IDX_FULL_W'(TANH_DEPTH)) idx = TIDX_W'(TANH_DEPTH - 1);
    else                                     idx = TIDX_W'(idx_full);
    entry         = OUT_W'(TANH_TABLE[idx]);
    res_next.pooled = pre[PIX_W-1] ? signed'(OUT_W'(0) - entry) : signed'(entry);
    res_next.done   = done3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1        <= tok.valid && tok.rd;
      v2        <= v1;
      v3        <= v2;
      res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    done1 <= tok.done;
    sum4  <= SUM_W'(tok.line) + SUM_W'(tok.pair);
    done2 <= done1;
    prod  <= PROD_W'(sum4) * PROD_W'(coef);
    done3 <= done2;
    pre   <= pre_next;
    res   <= res_next;
  end

endmodule

`default_nettype wire

FILE: sv/apst_queue.sv
// result queue in front of the output channel
`timescale 1ns / 1ps
`default_nettype none

module apst_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  apst_pkg::result_t push_data,
  input  logic              pop,
  output logic              head_valid,
  output apst_pkg::result_t head
);
  import apst_pkg::*;

  result_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + QCNT_W'(1);
    if (pop && !push) count_next = count - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

endmodule

`default_nettype wire
